// File: design/fbrd_pkg.sv
// Shared types and constants of the frame store drawing engine.
// Depends on nothing; every other design file refers to it by scoped names.
package fbrd_pkg;

	localparam int COORD_W = 6;
	localparam int COLOR_W = 24;
	localparam int ACTION_W = 3;

	localparam int DEF_PANEL_WIDTH = 32;
	localparam int DEF_PANEL_HEIGHT = 32;
	localparam int DEF_COLOR_BITS = 24;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_OUTLINE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_FILL = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_READ = 3'd4;

	// Work left for the back end after classification.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_WRITE,
		OP_OUTLINE,
		OP_FILL,
		OP_READ
	} back_op_t;

	typedef struct packed {
		back_op_t op;
		logic status;
		logic [COORD_W-1:0] x_pos;
		logic [COORD_W-1:0] y_pos;
		logic [COORD_W-1:0] rect_width;
		logic [COORD_W-1:0] rect_height;
		logic [COLOR_W-1:0] color;
	} cmd_t;

endpackage

// File: design/framebuffer_rectangle_drawer.sv
// Top level of the frame store drawing engine: front end, command queue
// and back end. Depends on fbrd_pkg, fbrd_front, fbrd_queue and fbrd_back.

// Each request (clear, pixel write, rectangle outline, filled rectangle or
// pixel read) gives exactly one result, in request order. The front end checks
// a request against the panel, registers it and passes it through a four-entry
// queue, so requests keep being taken while the back end draws until the queue
// fills. The back end has one frame store write port and writes at most one
// pixel per cycle: a clear walks all PANEL_WIDTH * PANEL_HEIGHT pixels, a
// rectangle its width * height pixels (an outline walks its interior too but
// writes only its edge), a pixel write or a read one pixel; each request is
// first taken from the queue and last loads the result register. Rejected and
// empty requests pass through the back end without touching the frame store.
// The frame store is not cleared at reset; read a pixel only after a clear or
// a write has set it.
module framebuffer_rectangle_drawer #(
	parameter int PANEL_WIDTH = fbrd_pkg::DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = fbrd_pkg::DEF_PANEL_HEIGHT,
	parameter int COLOR_BITS = fbrd_pkg::DEF_COLOR_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [fbrd_pkg::ACTION_W-1:0] action,
	input  logic [fbrd_pkg::COORD_W-1:0] x_pos,
	input  logic [fbrd_pkg::COORD_W-1:0] y_pos,
	input  logic [fbrd_pkg::COORD_W-1:0] rect_width,
	input  logic [fbrd_pkg::COORD_W-1:0] rect_height,
	input  logic [fbrd_pkg::COLOR_W-1:0] color,
	output logic out_valid,
	input  logic out_stall,
	output logic status,
	output logic [fbrd_pkg::COLOR_W-1:0] read_color
);

	logic cmd_valid;
	logic cmd_ready;
	fbrd_pkg::cmd_t cmd;
	logic pop_valid;
	logic pop_ready;
	fbrd_pkg::cmd_t pop_data;

	fbrd_front #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.x_pos(x_pos),
		.y_pos(y_pos),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.color(color),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd)
	);

	fbrd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(cmd_valid),
		.push_ready(cmd_ready),
		.push_data(cmd),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	fbrd_back #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT),
		.COLOR_BITS(COLOR_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.read_color(read_color)
	);

endmodule

// File: design/fbrd_front.sv
// Front end: accepts requests, checks them against the panel bounds and
// registers the classified command. Depends on fbrd_pkg.
module fbrd_front #(
	parameter int PANEL_WIDTH = fbrd_pkg::DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = fbrd_pkg::DEF_PANEL_HEIGHT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [fbrd_pkg::ACTION_W-1:0] action,
	input  logic [fbrd_pkg::COORD_W-1:0] x_pos,
	input  logic [fbrd_pkg::COORD_W-1:0] y_pos,
	input  logic [fbrd_pkg::COORD_W-1:0] rect_width,
	input  logic [fbrd_pkg::COORD_W-1:0] rect_height,
	input  logic [fbrd_pkg::COLOR_W-1:0] color,
	output logic cmd_valid,
	input  logic cmd_ready,
	output fbrd_pkg::cmd_t cmd
);

	localparam logic [fbrd_pkg::COORD_W:0] PW = (fbrd_pkg::COORD_W+1)'(PANEL_WIDTH);
	localparam logic [fbrd_pkg::COORD_W:0] PH = (fbrd_pkg::COORD_W+1)'(PANEL_HEIGHT);

	logic valid_s1;
	fbrd_pkg::cmd_t cmd_s1;
	fbrd_pkg::cmd_t classified;
	logic on_panel;
	logic rect_out;
	logic rect_empty;
	logic accept;

	assign in_stall = valid_s1 && !cmd_ready;
	assign accept = in_valid && !in_stall;
	assign cmd_valid = valid_s1;
	assign cmd = cmd_s1;

	always_comb begin
		on_panel = ({1'b0, x_pos} < PW) && ({1'b0, y_pos} < PH);
		rect_out = ({1'b0, x_pos} + {1'b0, rect_width} > PW)
			|| ({1'b0, y_pos} + {1'b0, rect_height} > PH);
		rect_empty = (rect_width == '0) || (rect_height == '0);

		classified.x_pos = x_pos;
		classified.y_pos = y_pos;
		classified.rect_width = rect_width;
		classified.rect_height = rect_height;
		classified.color = color;
		classified.op = fbrd_pkg::OP_NONE;
		classified.status = 1'b1;
		case (action)
			fbrd_pkg::ACT_CLEAR: begin
				classified.op = fbrd_pkg::OP_CLEAR;
				classified.status = 1'b0;
			end
			fbrd_pkg::ACT_WRITE: begin
				if (on_panel) begin
					classified.op = fbrd_pkg::OP_WRITE;
					classified.status = 1'b0;
				end
			end
			fbrd_pkg::ACT_OUTLINE, fbrd_pkg::ACT_FILL: begin
				// An empty rectangle inside the panel is done without drawing.
				if (!rect_out) begin
					classified.status = 1'b0;
					if (!rect_empty) begin
						classified.op = (action == fbrd_pkg::ACT_FILL)
							? fbrd_pkg::OP_FILL : fbrd_pkg::OP_OUTLINE;
					end
				end
			end
			fbrd_pkg::ACT_READ: begin
				if (on_panel) begin
					classified.op = fbrd_pkg::OP_READ;
					classified.status = 1'b0;
				end
			end
			default: begin
				classified.op = fbrd_pkg::OP_NONE;
				classified.status = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= classified;
		end
	end

endmodule

// File: design/fbrd_queue.sv
// Short command queue between the front end and the drawing back end.
// Depends on fbrd_pkg for the command type and the queue depth.
module fbrd_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  fbrd_pkg::cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output fbrd_pkg::cmd_t pop_data
);

	localparam int PTR_W = (fbrd_pkg::QUEUE_DEPTH > 1) ? $clog2(fbrd_pkg::QUEUE_DEPTH) : 1;
	localparam logic [PTR_W:0] FULL_COUNT = (PTR_W+1)'(fbrd_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(fbrd_pkg::QUEUE_DEPTH - 1);

	fbrd_pkg::cmd_t slots_q [fbrd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != FULL_COUNT);
	assign pop_valid = (count_q != '0);
	assign pop_data = slots_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: design/fbrd_back.sv
// Back end: walks the frame store for each command, one pixel per cycle,
// and holds the result register. Depends on fbrd_pkg.
module fbrd_back #(
	parameter int PANEL_WIDTH = fbrd_pkg::DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = fbrd_pkg::DEF_PANEL_HEIGHT,
	parameter int COLOR_BITS = fbrd_pkg::DEF_COLOR_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  fbrd_pkg::cmd_t pop_data,
	output logic out_valid,
	input  logic out_stall,
	output logic status,
	output logic [fbrd_pkg::COLOR_W-1:0] read_color
);

	localparam int ENTRIES = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = fbrd_pkg::COORD_W;
	localparam int PROD_W = 2 * CW + 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);
	localparam logic [CW:0] PW = (CW+1)'(PANEL_WIDTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_DONE
	} state_t;

	state_t state_q;
	fbrd_pkg::back_op_t op_q;
	logic [CW-1:0] w_q;
	logic [CW-1:0] h_q;
	logic [CW-1:0] dx_q;
	logic [CW-1:0] dy_q;
	logic [ADDR_W-1:0] addr_q;
	logic [COLOR_BITS-1:0] color_q;
	logic res_status_q;
	logic [fbrd_pkg::COLOR_W-1:0] res_color_q;
	logic out_valid_q;
	logic status_q;
	logic [fbrd_pkg::COLOR_W-1:0] read_color_q;

	logic [COLOR_BITS-1:0] frame_mem_q [ENTRIES];
	logic [COLOR_BITS-1:0] rd_data_q;

	logic [PROD_W-1:0] start_full;
	logic [ADDR_W-1:0] start_addr;
	logic last_col;
	logic last_row;
	logic edge_hit;
	logic [CW:0] row_step;
	logic wr_en;
	logic rd_en;
	logic [COLOR_BITS-1:0] wr_data;
	logic res_load;

	function automatic logic [COLOR_BITS-1:0] to_store(input logic [fbrd_pkg::COLOR_W-1:0] c);
		logic [COLOR_BITS-1:0] s;
		s = '0;
		for (int i = 0; i < COLOR_BITS; i++) begin
			if (i < fbrd_pkg::COLOR_W) s[i] = c[i];
		end
		return s;
	endfunction

	function automatic logic [fbrd_pkg::COLOR_W-1:0] to_out(input logic [COLOR_BITS-1:0] s);
		logic [fbrd_pkg::COLOR_W-1:0] c;
		c = '0;
		for (int i = 0; i < fbrd_pkg::COLOR_W; i++) begin
			if (i < COLOR_BITS) c[i] = s[i];
		end
		return c;
	endfunction

	assign pop_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign read_color = read_color_q;

	always_comb begin
		start_full = PROD_W'(PW) * PROD_W'(pop_data.y_pos) + PROD_W'(pop_data.x_pos);
		start_addr = ADDR_W'(start_full);
		last_col = (dx_q == w_q - CW'(1));
		last_row = (dy_q == h_q - CW'(1));
		edge_hit = (dx_q == '0) || (dy_q == '0) || last_col || last_row;
		// From the end of one row to the start of the next.
		row_step = PW - {1'b0, w_q} + (CW+1)'(1);
		wr_en = (state_q == S_EXEC) && ((op_q == fbrd_pkg::OP_CLEAR)
			|| (op_q == fbrd_pkg::OP_WRITE) || (op_q == fbrd_pkg::OP_FILL)
			|| ((op_q == fbrd_pkg::OP_OUTLINE) && edge_hit));
		rd_en = (state_q == S_EXEC) && (op_q == fbrd_pkg::OP_READ);
		wr_data = (op_q == fbrd_pkg::OP_CLEAR) ? '0 : color_q;
		res_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem_q[addr_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= frame_mem_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= fbrd_pkg::OP_NONE;
			w_q <= '0;
			h_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			addr_q <= '0;
			color_q <= '0;
			res_status_q <= 1'b0;
			res_color_q <= '0;
			out_valid_q <= 1'b0;
			status_q <= 1'b0;
			read_color_q <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						op_q <= pop_data.op;
						w_q <= pop_data.rect_width;
						h_q <= pop_data.rect_height;
						dx_q <= '0;
						dy_q <= '0;
						color_q <= to_store(pop_data.color);
						res_status_q <= pop_data.status;
						res_color_q <= '0;
						addr_q <= (pop_data.op == fbrd_pkg::OP_CLEAR) ? '0 : start_addr;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						fbrd_pkg::OP_CLEAR: begin
							if (addr_q == LAST_ADDR) begin
								state_q <= S_DONE;
							end else begin
								addr_q <= addr_q + ADDR_W'(1);
							end
						end
						fbrd_pkg::OP_WRITE: begin
							state_q <= S_DONE;
						end
						fbrd_pkg::OP_READ: begin
							state_q <= S_READ;
						end
						fbrd_pkg::OP_FILL, fbrd_pkg::OP_OUTLINE: begin
							if (last_col) begin
								if (last_row) begin
									state_q <= S_DONE;
								end else begin
									dx_q <= '0;
									dy_q <= dy_q + CW'(1);
									addr_q <= addr_q + ADDR_W'(row_step);
								end
							end else begin
								dx_q <= dx_q + CW'(1);
								addr_q <= addr_q + ADDR_W'(1);
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_READ: begin
					res_color_q <= to_out(rd_data_q);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_load) begin
						status_q <= res_status_q;
						read_color_q <= res_color_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/fbrd_checker.sv
// Port level checks of the drawing engine, bound to its top level.
// Depends on fbrd_pkg for field widths.
module fbrd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic status,
	input logic [fbrd_pkg::COLOR_W-1:0] read_color
);

	logic [3:0] pending_q;
	logic in_acc;
	logic out_acc;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Requests taken but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {3'b0, in_acc} - {3'b0, out_acc};
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_color))
		else $error("result changed while stalled");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("result without an outstanding request");

	a_idle_takes_request: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 4'd0 |-> !in_stall)
		else $error("stall while nothing is outstanding");

	a_ignored_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> read_color == '0)
		else $error("ignored request returned a colour");

endmodule

bind framebuffer_rectangle_drawer fbrd_checker u_fbrd_checker (.*);
